// ----- sv/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int TAG_BITS      = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int KIND_BITS     = 2;
  localparam int STATUS_BITS   = 2;
  localparam int OCC_BITS      = 5;

  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_LIST   = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } spq_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    kind_t                           kind;
    logic [TAG_BITS-1:0]             job_tag;
    logic signed [PRIORITY_BITS-1:0] job_priority;
  } spq_in_t;

  typedef struct packed {
    status_t                         status;
    logic [TAG_BITS-1:0]             out_tag;
    logic signed [PRIORITY_BITS-1:0] out_priority;
    logic                            last;
    logic [OCC_BITS-1:0]             occupancy;
  } spq_out_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]             tag;
    logic signed [PRIORITY_BITS-1:0] prio;
  } spq_entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t   op;
    spq_entry_t ins;
    spq_entry_t head;
  } cell_ctrl_t;

endpackage

// ----- sv/sorted_priority_queue.sv -----
// Insert and remove: one transaction per cycle while out_stall holds no result; the result is
// registered at acceptance. Listing N jobs: N results, one per free output cycle, with input
// stalled meanwhile. The chain rotates once per listed job.
// A result held by out_stall also stalls the input until it is taken.
// Reset (rst_n low, synchronous) empties the queue at once; slot contents are not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_data
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  spq_pkg::spq_state_t state_r, state_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CNT_BITS-1:0] rem_r, rem_nxt;
  logic                out_valid_r;
  spq_pkg::spq_out_t   out_r, out_d;
  logic                out_load;
  logic                out_free;
  logic                in_acc;
  logic                full, empty;
  logic [CNT_BITS+spq_pkg::OCC_BITS-1:0] occ_wide;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::spq_entry_t cell_q [CAPACITY];
  logic                cell_keep [CAPACITY];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != spq_pkg::ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CNT_BITS'(CAPACITY));
  assign empty    = (count_r == '0);
  assign occ_wide = {{spq_pkg::OCC_BITS{1'b0}}, count_nxt};

  // ---- cell chain ----
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                occupied;
      logic                is_tail;
      logic                left_keep;
      spq_pkg::spq_entry_t left_entry;
      spq_pkg::spq_entry_t right_entry;

      assign occupied = (CNT_BITS'(gi) < count_r);
      assign is_tail  = (count_r == CNT_BITS'(gi + 1));

      if (gi == 0) begin : g_first
        assign left_keep  = 1'b1;
        assign left_entry = ctrl.ins;
      end else begin : g_mid
        assign left_keep  = cell_keep[gi-1];
        assign left_entry = cell_q[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_entry = cell_q[gi];
      end else begin : g_inner
        assign right_entry = cell_q[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied),
        .is_tail     (is_tail),
        .left_keep   (left_keep),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (cell_q[gi]),
        .keep        (cell_keep[gi])
      );
    end
  endgenerate

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        if (in_acc && (in_data.kind == spq_pkg::KIND_LIST) && !empty) begin
          state_nxt = spq_pkg::ST_LIST;
        end
      end
      spq_pkg::ST_LIST: begin
        if (out_free && (rem_r == CNT_BITS'(1))) begin
          state_nxt = spq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  // ---- controller outputs ----
  always_comb begin
    ctrl.op       = spq_pkg::CELL_HOLD;
    ctrl.ins.tag  = in_data.job_tag;
    ctrl.ins.prio = in_data.job_priority;
    ctrl.head     = cell_q[0];
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_load      = 1'b0;
    out_d         = '0;

    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.kind)
            spq_pkg::KIND_INSERT: begin
              out_load = 1'b1;
              if (full) begin
                out_d.status = spq_pkg::STATUS_FULL;
              end else begin
                ctrl.op      = spq_pkg::CELL_INSERT;
                count_nxt    = count_r + CNT_BITS'(1);
                out_d.status = spq_pkg::STATUS_OK;
              end
            end
            spq_pkg::KIND_REMOVE: begin
              out_load = 1'b1;
              if (empty) begin
                out_d.status = spq_pkg::STATUS_EMPTY;
              end else begin
                ctrl.op            = spq_pkg::CELL_REMOVE;
                count_nxt          = count_r - CNT_BITS'(1);
                out_d.status       = spq_pkg::STATUS_OK;
                out_d.out_tag      = cell_q[0].tag;
                out_d.out_priority = cell_q[0].prio;
              end
            end
            spq_pkg::KIND_LIST: begin
              if (empty) begin
                out_load     = 1'b1;
                out_d.status = spq_pkg::STATUS_EMPTY;
              end else begin
                rem_nxt = count_r;
              end
            end
            default: ; // unused kind: swallowed without a result
          endcase
          out_d.last = 1'b1;
        end
      end
      spq_pkg::ST_LIST: begin
        if (out_free) begin
          out_load           = 1'b1;
          ctrl.op            = spq_pkg::CELL_ROTATE;
          rem_nxt            = rem_r - CNT_BITS'(1);
          out_d.status       = spq_pkg::STATUS_OK;
          out_d.out_tag      = cell_q[0].tag;
          out_d.out_priority = cell_q[0].prio;
          out_d.last         = (rem_r == CNT_BITS'(1));
        end
      end
      default: ;
    endcase

    out_d.occupancy = occ_wide[spq_pkg::OCC_BITS-1:0];
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/spq_cell.sv -----
// One queue slot: holds an entry and shifts it with its neighbours.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                is_tail,
  input  logic                left_keep,
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t entry,
  output logic                keep
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;

  // Equal priority stays ahead of the new job, so ties leave in arrival order.
  assign keep  = occupied && ($signed(entry_r.prio) >= $signed(ctrl.ins.prio));
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      spq_pkg::CELL_INSERT: begin
        if (!keep) begin
          entry_nxt = left_keep ? ctrl.ins : left_entry;
        end
      end
      spq_pkg::CELL_REMOVE: entry_nxt = right_entry;
      spq_pkg::CELL_ROTATE: entry_nxt = is_tail ? ctrl.head : right_entry;
      default:              entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the sorted priority queue: scoreboard class, stimulus and checking.
`timescale 1ns / 1ps

class queue_scoreboard #(int SLOTS = 16);
  spq_pkg::spq_entry_t mirror_jobs[SLOTS];
  int                  held;
  spq_pkg::spq_out_t   expected_replies[$];
  int                  mismatches;

  function new();
    held       = 0;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction

  // Work out the replies to an accepted request and update the mirror.
  function void note_request(spq_pkg::spq_in_t req);
    spq_pkg::spq_out_t rep;
    int                pos;
    rep      = '0;
    rep.last = 1'b1;
    case (req.kind)
      spq_pkg::KIND_INSERT: begin
        if (held >= SLOTS) begin
          rep.status = spq_pkg::STATUS_FULL;
        end else begin
          // first slot holding a strictly lower priority; ties stay ahead
          pos = held;
          for (int i = held - 1; i >= 0; i--)
            if ($signed(mirror_jobs[i].prio) < $signed(req.job_priority)) pos = i;
          for (int i = held; i > pos; i--) mirror_jobs[i] = mirror_jobs[i - 1];
          mirror_jobs[pos].tag  = req.job_tag;
          mirror_jobs[pos].prio = req.job_priority;
          held++;
          rep.status = spq_pkg::STATUS_OK;
        end
        rep.occupancy = held[spq_pkg::OCC_BITS-1:0];
        expected_replies.push_back(rep);
      end
      spq_pkg::KIND_REMOVE: begin
        if (held == 0) begin
          rep.status = spq_pkg::STATUS_EMPTY;
        end else begin
          rep.status       = spq_pkg::STATUS_OK;
          rep.out_tag      = mirror_jobs[0].tag;
          rep.out_priority = mirror_jobs[0].prio;
          for (int i = 1; i < held; i++) mirror_jobs[i - 1] = mirror_jobs[i];
          held--;
        end
        rep.occupancy = held[spq_pkg::OCC_BITS-1:0];
        expected_replies.push_back(rep);
      end
      spq_pkg::KIND_LIST: begin
        if (held == 0) begin
          rep.status = spq_pkg::STATUS_EMPTY;
          expected_replies.push_back(rep);
        end else begin
          for (int i = 0; i < held; i++) begin
            rep.status       = spq_pkg::STATUS_OK;
            rep.out_tag      = mirror_jobs[i].tag;
            rep.out_priority = mirror_jobs[i].prio;
            rep.last         = (i == held - 1);
            rep.occupancy    = held[spq_pkg::OCC_BITS-1:0];
            expected_replies.push_back(rep);
          end
        end
      end
      default: ;  // unused kind: no reply, no change
    endcase
  endfunction

  function void check_reply(spq_pkg::spq_out_t got);
    spq_pkg::spq_out_t want;
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected transaction status=%0d tag=%h prio=%0d last=%0d occ=%0d",
                 got.status, got.out_tag, $signed(got.out_priority), got.last,
                 got.occupancy);
      return;
    end
    want = expected_replies.pop_front();
    if (got.status !== want.status || got.out_tag !== want.out_tag ||
        got.out_priority !== want.out_priority || got.last !== want.last ||
        got.occupancy !== want.occupancy) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: expected status=%0d tag=%h prio=%0d last=%0d occ=%0d,",
                  " got status=%0d tag=%h prio=%0d last=%0d occ=%0d"},
                 want.status, want.out_tag, $signed(want.out_priority), want.last,
                 want.occupancy, got.status, got.out_tag, $signed(got.out_priority),
                 got.last, got.occupancy);
    end
  endfunction
endclass

module tb_top;

  localparam int             DEPTH        = 16;
  localparam int             RANDOM_JOBS  = 300;
  localparam int             HOLD_CYCLES  = 80;
  localparam int             DRAIN_CYCLES = 20;
  localparam int             CYCLE_LIMIT  = 200000;
  localparam spq_pkg::kind_t KIND_UNUSED  = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  spq_pkg::spq_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  spq_pkg::spq_out_t out_data;

  queue_scoreboard #(DEPTH) sb;
  int   sent_count  = 0;
  int   cycle_count = 0;
  logic hold_request = 1'b0;
  logic hold_done    = 1'b0;
  logic quiet;

  // no idling on either side over this stretch
  assign quiet = (sent_count >= 100) && (sent_count < 180);

  sorted_priority_queue #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_data);
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 24);
      end
    end
  end

  task automatic send_request(input spq_pkg::kind_t k,
                              input logic [spq_pkg::TAG_BITS-1:0] tag,
                              input logic signed [spq_pkg::PRIORITY_BITS-1:0] prio);
    spq_pkg::spq_in_t req;
    req.kind         = k;
    req.job_tag      = tag;
    req.job_priority = prio;
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    sent_count++;
  endtask

  function automatic logic signed [spq_pkg::PRIORITY_BITS-1:0] pick_priority();
    case ($urandom_range(5))
      0, 1:    return 16'($urandom_range(4)) - 16'sd2;  // narrow band for ties
      2:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic spq_pkg::kind_t pick_kind(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 5) return KIND_UNUSED;
    if (r < 15) return spq_pkg::KIND_LIST;
    if (r < (filling ? 75 : 35)) return spq_pkg::KIND_INSERT;
    return spq_pkg::KIND_REMOVE;
  endfunction

  initial begin
    bit             filling;
    int             jobs_done;
    spq_pkg::kind_t k;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, ignored kind, extremes and ties
    send_request(spq_pkg::KIND_LIST,   32'h0, 16'sh0);
    send_request(spq_pkg::KIND_REMOVE, 32'h0, 16'sh0);
    send_request(KIND_UNUSED,          32'hFFFF_FFFF, 16'shFFFF);
    send_request(spq_pkg::KIND_INSERT, 32'h0000_0000, 16'sh0000);
    send_request(spq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'sh7FFF);
    send_request(spq_pkg::KIND_INSERT, 32'h0000_0001, 16'sh8000);
    send_request(spq_pkg::KIND_INSERT, 32'h0000_0002, 16'sh0000);
    send_request(spq_pkg::KIND_INSERT, 32'h0000_0003, 16'shFFFF);
    send_request(spq_pkg::KIND_INSERT, 32'h0000_0004, 16'sh7FFF);
    send_request(spq_pkg::KIND_INSERT, 32'h0000_0005, 16'sh8000);  // ties the rear entry
    send_request(spq_pkg::KIND_LIST,   32'h0, 16'sh0);
    send_request(spq_pkg::KIND_REMOVE, 32'h0, 16'sh0);
    while (sb.held < DEPTH) send_request(spq_pkg::KIND_INSERT, $urandom, pick_priority());
    send_request(spq_pkg::KIND_INSERT, 32'hA5A5_5A5A, 16'sh1234);   // full
    send_request(spq_pkg::KIND_LIST,   32'h0, 16'sh0);
    send_request(spq_pkg::KIND_REMOVE, 32'h0, 16'sh0);

    // random phases, alternately filling and draining the queue
    filling   = 1'b0;
    jobs_done = 0;
    while (jobs_done < RANDOM_JOBS) begin
      if (sb.held == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      else if (sb.held == 0) filling = 1'b1;
      k = pick_kind(filling);
      if (k != KIND_UNUSED) jobs_done++;
      if (sent_count >= 250) hold_request = 1'b1;
      send_request(k, $urandom, pick_priority());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("sorted_priority_queue verification clean");
    else
      $display("sorted_priority_queue verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
bench/tb_top.sv
